@@ sv/hvau_pkg.sv @@
// Package for the heightmap vertex attribute unit: payload and pipeline types,
// register codes, constants and the per-stage arithmetic functions.
// Depends on nothing; every other file imports it.
package hvau_pkg;

   localparam int STAGES      = 27;
   localparam int SQ_STAGE    = 1;
   localparam int SUM_STAGE   = 2;
   localparam int DIV_FIRST   = 3;
   localparam int SQRT_FIRST  = 19;
   localparam int NORM_TOP    = 30;
   localparam int TEX_TOP     = 15;
   localparam logic [10:0] MAX_GRID   = 11'd1024;
   localparam logic [24:0] RECIP_255  = 25'h1010102;
   localparam logic [15:0] UNIT_Q14   = 16'd16384;

   typedef enum logic [2:0] {
      CSR_GRID_LENGTH = 3'd0,
      CSR_SPACING     = 3'd1,
      CSR_AMPLITUDE   = 3'd2,
      CSR_ORIGIN_X    = 3'd3,
      CSR_ORIGIN_Z    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [9:0] col;
      logic [9:0] row;
      logic [7:0] height_here;
      logic [7:0] height_side;
      logic [7:0] height_below;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic [15:0]        pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } rsp_type;

   typedef struct packed {
      logic [10:0] grid_length;
      logic [15:0] spacing;
      logic [15:0] amplitude;
      logic [23:0] origin_x;
      logic [23:0] origin_z;
   } cfg_type;

   typedef struct packed {
      logic [31:0]       pos_x;
      logic [31:0]       pos_z;
      logic [15:0]       pos_y;
      logic [23:0]       y_prod;
      logic [10:0]       len;
      logic              sat_u;
      logic              sat_v;
      logic [10:0]       rem_u;
      logic [10:0]       rem_v;
      logic [15:0]       tex_u;
      logic [15:0]       tex_v;
      logic [2:0][23:0]  mag;
      logic [2:0]        neg;
      logic [2:0][47:0]  sq;
      logic [49:0]       sum;
      logic              zero_sum;
      logic [2:0][50:0]  rem;
      logic [2:0][31:0]  quo;
      logic [2:0][31:0]  root;
   } pipe_type;

   function automatic pipe_type pipe_prep(input req_type r, input cfg_type c);
      pipe_type    p;
      logic [10:0] len;
      logic [25:0] px_prod;
      logic [25:0] pz_prod;
      logic [8:0]  dx;
      logic [8:0]  dz;
      logic [8:0]  ax;
      logic [8:0]  az;
      p = '0;
      len = (c.grid_length > MAX_GRID) ? MAX_GRID : c.grid_length;
      px_prod = {10'd0, c.spacing} * {16'd0, r.col};
      pz_prod = {10'd0, c.spacing} * {16'd0, r.row};
      p.pos_x = {{8{c.origin_x[23]}}, c.origin_x} + {6'd0, px_prod};
      p.pos_z = {{8{c.origin_z[23]}}, c.origin_z} - {6'd0, pz_prod};
      p.y_prod = {16'd0, r.height_here} * {8'd0, c.amplitude};
      p.len = len;
      p.sat_u = (len == 11'd0) || ({1'b0, r.col} >= len);
      p.sat_v = (len == 11'd0) || ({1'b0, r.row} >= len);
      p.rem_u = p.sat_u ? 11'd0 : {1'b0, r.col};
      p.rem_v = p.sat_v ? 11'd0 : {1'b0, r.row};
      dx = r.col[0] ? ({1'b0, r.height_side} - {1'b0, r.height_below})
                    : ({1'b0, r.height_here} - {1'b0, r.height_side});
      dz = {1'b0, r.height_below} - {1'b0, r.height_here};
      ax = dx[8] ? (9'd0 - dx) : dx;
      az = dz[8] ? (9'd0 - dz) : dz;
      p.mag[0] = {16'd0, ax[7:0]} * {8'd0, c.amplitude};
      p.mag[1] = 24'd255 * {8'd0, c.spacing};
      p.mag[2] = {16'd0, az[7:0]} * {8'd0, c.amplitude};
      p.neg = {dz[8], 1'b0, dx[8]};
      return p;
   endfunction

   function automatic pipe_type pipe_step(input int k, input pipe_type d);
      pipe_type    p;
      logic [48:0] yp;
      logic [50:0] r;
      logic [11:0] t;
      logic [31:0] x;
      logic [31:0] rs;
      logic [31:0] trial;
      logic [31:0] bv;
      int          bit_pos;
      int          n;
      p = d;
      if (k == SQ_STAGE) begin
         for (int i = 0; i < 3; i++) begin
            p.sq[i] = {24'd0, d.mag[i]} * {24'd0, d.mag[i]};
         end
         yp = {25'd0, d.y_prod} * {24'd0, RECIP_255};
         p.pos_y = yp[47:32];
      end else if (k == SUM_STAGE) begin
         p.sum = {2'd0, d.sq[0]} + {2'd0, d.sq[1]} + {2'd0, d.sq[2]};
         p.zero_sum = (p.sum == 50'd0);
         for (int i = 0; i < 3; i++) begin
            p.rem[i] = {4'd0, d.sq[i][47:1]};
            p.quo[i] = '0;
            p.root[i] = '0;
         end
      end else if (k >= DIV_FIRST && k < SQRT_FIRST) begin
         for (int s = 0; s < 2; s++) begin
            bit_pos = NORM_TOP - 2 * (k - DIV_FIRST) - s;
            if (bit_pos >= 0) begin
               for (int i = 0; i < 3; i++) begin
                  r = {p.rem[i][49:0], (bit_pos == NORM_TOP) ? p.sq[i][0] : 1'b0};
                  if (r >= {1'b0, p.sum}) begin
                     r = r - {1'b0, p.sum};
                     p.quo[i][bit_pos[4:0]] = 1'b1;
                  end
                  p.rem[i] = r;
               end
            end
            bit_pos = TEX_TOP - 2 * (k - DIV_FIRST) - s;
            if (bit_pos >= 0) begin
               t = {p.rem_u, 1'b0};
               if (t >= {1'b0, p.len}) begin
                  t = t - {1'b0, p.len};
                  p.tex_u[bit_pos[3:0]] = 1'b1;
               end
               p.rem_u = t[10:0];
               t = {p.rem_v, 1'b0};
               if (t >= {1'b0, p.len}) begin
                  t = t - {1'b0, p.len};
                  p.tex_v[bit_pos[3:0]] = 1'b1;
               end
               p.rem_v = t[10:0];
            end
         end
      end else if (k >= SQRT_FIRST) begin
         for (int s = 0; s < 2; s++) begin
            n = 2 * (k - SQRT_FIRST) + s;
            bv = 32'd1 << (NORM_TOP - 2 * n);
            for (int i = 0; i < 3; i++) begin
               x = p.quo[i];
               rs = p.root[i];
               trial = rs + bv;
               if (x >= trial) begin
                  p.quo[i] = x - trial;
                  p.root[i] = (rs >> 1) + bv;
               end else begin
                  p.root[i] = rs >> 1;
               end
            end
         end
      end
      return p;
   endfunction

   function automatic rsp_type rsp_build(input pipe_type d);
      rsp_type           o;
      logic [31:0]       rp;
      logic [2:0][15:0]  nv;
      for (int i = 0; i < 3; i++) begin
         rp = d.root[i] + 32'd1;
         nv[i] = d.neg[i] ? (16'd0 - rp[16:1]) : rp[16:1];
      end
      o.pos_x = d.pos_x;
      o.pos_y = d.pos_y;
      o.pos_z = d.pos_z;
      o.tex_u = d.sat_u ? 16'hFFFF : d.tex_u;
      o.tex_v = d.sat_v ? 16'hFFFF : d.tex_v;
      o.normal_x = d.zero_sum ? 16'd0 : nv[0];
      o.normal_y = d.zero_sum ? UNIT_Q14 : nv[1];
      o.normal_z = d.zero_sum ? 16'd0 : nv[2];
      return o;
   endfunction

endpackage

@@ sv/heightmap_vertex_attribute_unit_core.sv @@
// Heightmap vertex attribute unit, top level: register file and the vertex pipeline.
// Depends on hvau_pkg for types, constants and the stage functions.
// Throughput is one request per cycle unless rsp_stall holds the output; the 27
// pipeline stages and the output register advance independently, so bubbles close
// up while a result waits.
// Synchronous active-high reset clears all valid bits and loads the register defaults.
module heightmap_vertex_attribute_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hvau_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hvau_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import hvau_pkg::*;

   cfg_type              cfg_ff;
   pipe_type             pipe_ff [STAGES];
   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    adv;
   logic                 out_adv;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_length <= 11'd256;
         cfg_ff.spacing     <= 16'd256;
         cfg_ff.amplitude   <= 16'd256;
         cfg_ff.origin_x    <= 24'd0;
         cfg_ff.origin_z    <= 24'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_LENGTH: cfg_ff.grid_length <= csr_wdata[10:0];
            CSR_SPACING:     cfg_ff.spacing     <= csr_wdata[15:0];
            CSR_AMPLITUDE:   cfg_ff.amplitude   <= csr_wdata[15:0];
            CSR_ORIGIN_X:    cfg_ff.origin_x    <= csr_wdata;
            CSR_ORIGIN_Z:    cfg_ff.origin_z    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_adv;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pipe_ff[0] <= pipe_prep(req_data, cfg_ff);
      end
   end

   for (genvar k = 1; k < STAGES; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_step(k, pipe_ff[k-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_ff <= rsp_build(pipe_ff[STAGES-1]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/hvau_checker.sv @@
// Port-level assertions for the heightmap vertex attribute unit, bound to the top level.
// Depends on hvau_pkg for the payload types.
module hvau_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hvau_pkg::rsp_type rsp_data
);
   import hvau_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   a_no_stall_when_open: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the result side is open");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_normal_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.normal_y[15] && (rsp_data.normal_y <= $signed(UNIT_Q14)))
      else $error("normal y component out of range");

endmodule

bind heightmap_vertex_attribute_unit_core hvau_checker u_hvau_checker (.*);
